[sv/mbp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mbp_pkg;

    // Code and count geometry.
    localparam int CODE_W          = 32;
    localparam int MAX_CODE_BITS   = 32;
    localparam int SHIFT_W         = 2 * CODE_W;
    localparam int NBITS_W         = 6;
    localparam int REM_W           = 7;
    localparam int INDEX_W         = 24;
    localparam int CAP_W           = 24;
    localparam int COUNT_BITS      = 24;
    localparam int APB_DATA_W      = 32;
    localparam int APB_ADDR_W      = 3;

    // Register map and reset values.
    localparam logic [APB_ADDR_W-1:0] ADDR_CAPACITY  = 3'd0;
    localparam logic [CAP_W-1:0]      CAPACITY_RESET = 24'hFF_FFFF;

    // Bit position that the next appended bit fills after a byte restarts.
    localparam logic [2:0] TOP_BIT = 3'd7;

    // Item kinds.
    localparam logic KIND_APPEND = 1'b0;
    localparam logic KIND_FLUSH  = 1'b1;

    // Input word.
    typedef struct packed {
        logic               kind;
        logic [CODE_W-1:0]  code_value;
        logic [NBITS_W-1:0] bit_count;
    } t_in_word;

    // Result word.
    typedef struct packed {
        logic [7:0]         out_byte;
        logic [INDEX_W-1:0] byte_index;
        logic               within_capacity;
        logic               last;
    } t_out_word;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic flush;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic rem_zero;
        logic rem_after_zero;
    } t_dp_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WORK,
        ST_FLUSH
    } t_state;

endpackage

`default_nettype wire

[sv/mbp_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module mbp_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_in_kind,
    input  wire mbp_pkg::t_dp_status i_status,
    output mbp_pkg::t_dp_cmd         o_cmd,
    output logic                     o_in_stall
);

    mbp_pkg::t_state r_state;
    mbp_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mbp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            mbp_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_in_kind == mbp_pkg::KIND_FLUSH) begin
                        n_state = mbp_pkg::ST_FLUSH;
                    end else begin
                        n_state = mbp_pkg::ST_WORK;
                    end
                end
            end
            mbp_pkg::ST_WORK: begin
                if (i_status.rem_zero) begin
                    n_state = mbp_pkg::ST_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.step = 1'b1;
                    if (i_status.rem_after_zero) begin
                        n_state = mbp_pkg::ST_IDLE;
                    end
                end
            end
            mbp_pkg::ST_FLUSH: begin
                if (i_status.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = mbp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mbp_pkg::ST_IDLE;
            end
        endcase
    end

    // Only one command is issued in a cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.step, o_cmd.flush}))
        else $error("more than one datapath command at once");

    // A step or flush is never issued while the result register cannot take a word.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.step || o_cmd.flush) |-> i_status.out_free)
        else $error("datapath command issued while result register is blocked");

    // Input is only taken in the idle state.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state != mbp_pkg::ST_IDLE))
        else $error("controller stayed idle after taking a word");

endmodule

`default_nettype wire

[sv/mbp_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module mbp_dp #(
    parameter int COUNT_BITS = mbp_pkg::COUNT_BITS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire mbp_pkg::t_dp_cmd               i_cmd,
    input  wire mbp_pkg::t_in_word              i_in_word,
    input  wire logic [mbp_pkg::CAP_W-1:0]      i_capacity,
    input  wire logic                           i_out_stall,
    output mbp_pkg::t_dp_status                 o_status,
    output logic                                o_out_valid,
    output mbp_pkg::t_out_word                  o_out_word
);

    localparam int CMP_W = (COUNT_BITS > mbp_pkg::CAP_W) ? COUNT_BITS : mbp_pkg::CAP_W;

    logic [mbp_pkg::SHIFT_W-1:0] r_shreg;
    logic [mbp_pkg::REM_W-1:0]   r_rem;
    logic [7:0]                  r_partial;
    logic [2:0]                  r_pos;
    logic [COUNT_BITS-1:0]       r_cnt;
    logic                        r_out_valid;
    mbp_pkg::t_out_word          r_out;

    logic [mbp_pkg::REM_W-1:0]   w_n;
    logic [mbp_pkg::REM_W-1:0]   w_cnt_ext;
    logic [3:0]                  w_free;
    logic [3:0]                  w_k;
    logic [7:0]                  w_bits;
    logic [7:0]                  w_partial_new;
    logic                        w_full;
    logic [mbp_pkg::REM_W-1:0]   w_rem_after;
    logic                        w_emit;
    logic [7:0]                  w_emit_byte;
    logic                        w_emit_last;
    logic                        w_out_free;

    // Clamp the requested bit count to the largest code length.
    always_comb begin
        w_cnt_ext = {1'b0, i_in_word.bit_count};
        if (w_cnt_ext > mbp_pkg::REM_W'(mbp_pkg::MAX_CODE_BITS)) begin
            w_n = mbp_pkg::REM_W'(mbp_pkg::MAX_CODE_BITS);
        end else begin
            w_n = w_cnt_ext;
        end
    end

    // One step places as many of the remaining bits as fit in the current byte, at most eight.
    always_comb begin
        w_free        = {1'b0, r_pos} + 4'd1;
        w_k           = (r_rem < mbp_pkg::REM_W'(w_free)) ? r_rem[3:0] : w_free;
        w_bits        = r_shreg[mbp_pkg::SHIFT_W-1 -: 8] >> (4'd8 - w_k);
        w_partial_new = r_partial | (w_bits << (w_free - w_k));
        w_full        = (w_k == w_free);
        w_rem_after   = r_rem - mbp_pkg::REM_W'(w_k);
    end

    // A byte leaves on a step that fills it, or on a flush of a partial byte.
    always_comb begin
        w_emit      = 1'b0;
        w_emit_byte = w_partial_new;
        w_emit_last = 1'b0;
        if (i_cmd.step && w_full) begin
            w_emit      = 1'b1;
            w_emit_last = (w_rem_after < mbp_pkg::REM_W'(8));
        end else if (i_cmd.flush && (r_pos != mbp_pkg::TOP_BIT)) begin
            w_emit      = 1'b1;
            w_emit_byte = r_partial;
            w_emit_last = 1'b1;
        end
    end

    assign w_out_free = !r_out_valid || !i_out_stall;

    // Code shift register and remaining bit count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
        end else if (i_cmd.load) begin
            r_rem <= (i_in_word.kind == mbp_pkg::KIND_APPEND) ? w_n : '0;
        end else if (i_cmd.step) begin
            r_rem <= w_rem_after;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_shreg <= {{(mbp_pkg::SHIFT_W - mbp_pkg::CODE_W){1'b0}}, i_in_word.code_value}
                       << (mbp_pkg::REM_W'(mbp_pkg::SHIFT_W) - w_n);
        end else if (i_cmd.step) begin
            r_shreg <= r_shreg << w_k;
        end
    end

    // Partial byte and fill position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_pos     <= mbp_pkg::TOP_BIT;
        end else if (w_emit) begin
            r_partial <= '0;
            r_pos     <= mbp_pkg::TOP_BIT;
        end else if (i_cmd.step) begin
            r_partial <= w_partial_new;
            r_pos     <= r_pos - w_k[2:0];
        end
    end

    // Running byte counter, saturating at its maximum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_emit && (r_cnt != {COUNT_BITS{1'b1}})) begin
            r_cnt <= r_cnt + COUNT_BITS'(1);
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out.out_byte        <= w_emit_byte;
            r_out.byte_index      <= mbp_pkg::INDEX_W'(r_cnt);
            r_out.within_capacity <= (CMP_W'(r_cnt) < CMP_W'(i_capacity));
            r_out.last            <= w_emit_last;
        end
    end

    assign o_out_valid             = r_out_valid;
    assign o_out_word              = r_out;
    assign o_status.out_free       = w_out_free;
    assign o_status.rem_zero       = (r_rem == '0);
    assign o_status.rem_after_zero = (w_rem_after == '0);

    // A word never overwrites a stalled result.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !w_emit)
        else $error("result overwritten while stalled");

    // Every emitted byte restarts the partial byte.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> (r_pos == mbp_pkg::TOP_BIT) && (r_partial == '0))
        else $error("partial byte not restarted after emit");

    // Remaining bits only grow on a load.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.load |=> (r_rem <= $past(r_rem)))
        else $error("remaining bit count grew without a load");

    // The byte counter never moves backward.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_cnt >= $past(r_cnt)))
        else $error("byte counter decreased");

endmodule

`default_nettype wire

[sv/msb_first_bit_packer_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// An input word is taken in an idle cycle; each following work cycle places up to
// eight bits, stopping at a byte boundary, while the result register can take a byte.
// A flush is done once the result register is free; the next word is taken the cycle
// after the last step or flush, so no new word is taken until the last one is finished.
// Each byte enters the result register on its step and shows there the cycle after.
// Synchronous active-low reset clears the packer, the counter and sets capacity to max.
module msb_first_bit_packer_unit #(
    parameter int COUNT_BITS = mbp_pkg::COUNT_BITS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire mbp_pkg::t_in_word                   i_in_word,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output mbp_pkg::t_out_word                       o_out_word,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [mbp_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire logic [mbp_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [mbp_pkg::APB_DATA_W-1:0]           prdata,
    output logic                                     pready
);

    logic [mbp_pkg::CAP_W-1:0] r_capacity;
    mbp_pkg::t_dp_cmd          w_cmd;
    mbp_pkg::t_dp_status       w_status;

    // Capacity register write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= mbp_pkg::CAPACITY_RESET;
        end else if (psel && penable && pwrite && (paddr == mbp_pkg::ADDR_CAPACITY)) begin
            r_capacity <= pwdata[mbp_pkg::CAP_W-1:0];
        end
    end

    // Register readback.
    always_comb begin
        if (paddr == mbp_pkg::ADDR_CAPACITY) begin
            prdata = mbp_pkg::APB_DATA_W'(r_capacity);
        end else begin
            prdata = '0;
        end
    end

    assign pready = 1'b1;

    mbp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_kind  (i_in_word.kind),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    mbp_dp #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_word   (i_in_word),
        .i_capacity  (r_capacity),
        .i_out_stall (i_out_stall),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

`default_nettype wire

[verif/msb_first_bit_packer_checker.sv]
`timescale 1ns / 1ps

// Watches the input, result and register channels of the packer, predicts the
// packed byte stream and compares every result word against it.
module msb_first_bit_packer_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    input  wire logic                            i_in_stall,
    input  wire mbp_pkg::t_in_word               i_in_word,
    input  wire logic                            i_out_valid,
    input  wire logic                            i_out_stall,
    input  wire mbp_pkg::t_out_word              i_out_word,
    input  wire logic                            i_psel,
    input  wire logic                            i_penable,
    input  wire logic                            i_pwrite,
    input  wire logic [mbp_pkg::APB_ADDR_W-1:0]  i_paddr,
    input  wire logic [mbp_pkg::APB_DATA_W-1:0]  i_pwdata,
    input  wire logic [mbp_pkg::APB_DATA_W-1:0]  i_prdata,
    input  wire logic                            i_pready,
    output int                                   o_mismatches,
    output int                                   o_pending,
    output logic [mbp_pkg::INDEX_W-1:0]          o_stream_count
);
    import mbp_pkg::*;

    // Predicted packer state and the capacity register copy.
    logic [7:0]            acc_byte;
    logic [2:0]            bit_pos;
    logic [COUNT_BITS-1:0] stream_count;
    logic [CAP_W-1:0]      capacity;

    // Bytes predicted but not yet seen on the result channel, oldest first.
    t_out_word expected_bytes[$];
    int        mismatches = 0;

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        // Keep the log readable when the design is badly broken.
        if (mismatches < 40) begin
            $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        end
        mismatches++;
    endtask

    // Closes the current byte: builds its result word and restarts the byte.
    function automatic t_out_word take_byte();
        t_out_word b;
        b.out_byte        = acc_byte;
        b.byte_index      = stream_count[INDEX_W-1:0];
        b.within_capacity = (stream_count < COUNT_BITS'(capacity));
        b.last            = 1'b0;
        // The stream counter sticks at its maximum.
        if (stream_count != '1) begin
            stream_count = stream_count + 1'b1;
        end
        acc_byte = '0;
        bit_pos  = TOP_BIT;
        return b;
    endfunction

    // Works out the bytes that one accepted input word completes.
    task automatic predict_word(input t_in_word w);
        t_out_word batch[4];
        int        n_out;
        int        n_bits;
        n_out = 0;
        if (w.kind == KIND_FLUSH) begin
            // A flush only emits when some bits are pending.
            if (bit_pos != TOP_BIT) begin
                batch[n_out] = take_byte();
                n_out++;
            end
        end else begin
            // Oversized counts are clamped to the code width.
            n_bits = (int'(w.bit_count) > MAX_CODE_BITS) ? MAX_CODE_BITS : int'(w.bit_count);
            for (int k = n_bits - 1; k >= 0; k--) begin
                if (w.code_value[k]) begin
                    acc_byte[bit_pos] = 1'b1;
                end
                if (bit_pos == 3'd0) begin
                    batch[n_out] = take_byte();
                    n_out++;
                end else begin
                    bit_pos = bit_pos - 1'b1;
                end
            end
        end
        if (n_out > 0) begin
            batch[n_out-1].last = 1'b1;
        end
        for (int k = 0; k < n_out; k++) begin
            expected_bytes.push_back(batch[k]);
        end
    endtask

    // Predict on every accepted input word and compare every accepted result word.
    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            acc_byte     = '0;
            bit_pos      = TOP_BIT;
            stream_count = '0;
            capacity     = CAPACITY_RESET;
            expected_bytes.delete();
        end else begin
            // Track register writes and check read data.
            if (i_psel && i_penable && i_pready && i_paddr == ADDR_CAPACITY) begin
                if (i_pwrite) begin
                    capacity = i_pwdata[CAP_W-1:0];
                end else if (i_prdata[CAP_W-1:0] !== capacity) begin
                    report_mismatch("capacity read", i_prdata, capacity);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_word(i_in_word);
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch("result word with nothing expected", i_out_word, 0);
                end else begin
                    want = expected_bytes.pop_front();
                    if (i_out_word.out_byte !== want.out_byte) begin
                        report_mismatch("out_byte", i_out_word.out_byte, want.out_byte);
                    end
                    if (i_out_word.byte_index !== want.byte_index) begin
                        report_mismatch("byte_index", i_out_word.byte_index, want.byte_index);
                    end
                    if (i_out_word.within_capacity !== want.within_capacity) begin
                        report_mismatch("within_capacity", i_out_word.within_capacity,
                                        want.within_capacity);
                    end
                    if (i_out_word.last !== want.last) begin
                        report_mismatch("last", i_out_word.last, want.last);
                    end
                end
            end
        end
        o_mismatches   <= mismatches;
        o_pending      <= expected_bytes.size();
        o_stream_count <= stream_count[INDEX_W-1:0];
    end

endmodule

[verif/msb_first_bit_packer_unit_tb.sv]
`timescale 1ns / 1ps

module msb_first_bit_packer_unit_tb;
    import mbp_pkg::*;

    localparam int ITEMS_PER_PHASE = 73;
    localparam int NUM_PHASES      = 6;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 12;
    localparam int STALL_LIMIT     = 3000;

    typedef enum int {
        RX_FREE,
        RX_HALF,
        RX_LIGHT,
        RX_COMB
    } t_rx_pattern;

    // Block inputs, all known from time zero.
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    t_in_word              i_in_word   = '0;
    logic                  i_out_stall = 1'b0;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [APB_ADDR_W-1:0] paddr       = '0;
    logic [APB_DATA_W-1:0] pwdata      = '0;

    // Block outputs.
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out_word             o_out_word;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Checker status.
    int                    mismatches;
    int                    pending_bytes;
    logic [INDEX_W-1:0]    stream_count;

    // Sender burst state, receiver pattern state and the long hold.
    int                    burst_left     = 5;
    t_rx_pattern           rx_pattern     = RX_FREE;
    int                    rx_left        = 0;
    int                    hold_count     = 0;
    logic                  hold_req       = 1'b0;
    logic                  hold_done      = 1'b0;
    int                    stalled_cycles = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    msb_first_bit_packer_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    msb_first_bit_packer_checker packer_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_in_word      (i_in_word),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_out_word     (o_out_word),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_prdata       (prdata),
        .i_pready       (pready),
        .o_mismatches   (mismatches),
        .o_pending      (pending_bytes),
        .o_stream_count (stream_count)
    );

    function automatic t_in_word make_word(input logic kind, input logic [CODE_W-1:0] code,
                                           input int count);
        t_in_word w;
        w.kind       = kind;
        w.code_value = code;
        w.bit_count  = NBITS_W'(count);
        return w;
    endfunction

    // Mostly appends of ordinary widths, with empty, full and oversized counts mixed in.
    function automatic t_in_word random_word();
        t_in_word w;
        int       pick;
        w.kind = ($urandom_range(0, 6) == 0) ? KIND_FLUSH : KIND_APPEND;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            w.code_value = '0;
        end else if (pick == 1) begin
            w.code_value = '1;
        end else begin
            w.code_value = $urandom;
        end
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            w.bit_count = '0;
        end else if (pick == 1) begin
            w.bit_count = NBITS_W'($urandom_range(MAX_CODE_BITS + 1, 63));
        end else if (pick < 4) begin
            w.bit_count = NBITS_W'(MAX_CODE_BITS);
        end else begin
            w.bit_count = NBITS_W'($urandom_range(1, MAX_CODE_BITS - 1));
        end
        return w;
    endfunction

    // Offers one word and waits for it to be taken; bursts end with a random gap.
    task automatic offer_word(input t_in_word w);
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        if (burst_left > 0) begin
            burst_left--;
        end
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
    endtask

    // Stops sending and waits until every predicted byte has arrived and the block has
    // finished any word that completes no byte.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_bytes != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register access: a setup phase, then an access phase held until pready.
    task automatic apb_access(input logic write, input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= ADDR_CAPACITY;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Writes the capacity with junk in the unused upper bits, then reads it back.
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        apb_access(1'b1, {8'($urandom_range(0, 255)), cap});
        apb_access(1'b0, '0);
    endtask

    // Receiver: a changing stall pattern, and one long hold when asked for.
    always @(posedge i_clk) begin
        if (hold_req && !hold_done) begin
            i_out_stall <= 1'b1;
            hold_count++;
            if (hold_count >= HOLD_CYCLES) begin
                hold_done = 1'b1;
            end
        end else begin
            if (rx_left == 0) begin
                rx_pattern = t_rx_pattern'($urandom_range(0, 3));
                rx_left    = $urandom_range(20, 120);
            end
            rx_left--;
            case (rx_pattern)
                RX_FREE: begin
                    i_out_stall <= 1'b0;
                end
                RX_HALF: begin
                    i_out_stall <= ($urandom_range(0, 1) == 1);
                end
                RX_LIGHT: begin
                    i_out_stall <= ($urandom_range(0, 4) == 0);
                end
                default: begin
                    i_out_stall <= ((rx_left % 8) < 3);
                end
            endcase
        end
    end

    // Watchdog: ends the run when no word moves on either channel for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            stalled_cycles <= 0;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
            if (stalled_cycles >= STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Stimulus: directed words, then random phases under different capacities.
    initial begin
        logic [CAP_W-1:0] cap;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words at reset capacity.
        offer_word(make_word(KIND_FLUSH, 32'hDEAD_BEEF, 17));   // flush with nothing pending
        offer_word(make_word(KIND_APPEND, 32'hFFFF_FFFF, 0));   // empty append
        offer_word(make_word(KIND_APPEND, 32'hFFFF_FFFF, 32));
        offer_word(make_word(KIND_APPEND, 32'h0000_0000, 32));
        offer_word(make_word(KIND_APPEND, 32'h0000_0001, 1));
        offer_word(make_word(KIND_FLUSH, 32'h0, 0));             // pads a single bit
        offer_word(make_word(KIND_APPEND, 32'h0000_0055, 7));
        offer_word(make_word(KIND_APPEND, 32'h0000_0001, 1));   // closes a byte exactly
        offer_word(make_word(KIND_APPEND, 32'h0000_0005, 3));
        offer_word(make_word(KIND_APPEND, 32'hA5A5_A5A5, 32));  // four bytes from mid-byte
        offer_word(make_word(KIND_FLUSH, 32'hFFFF_FFFF, 63));   // operands ignored
        offer_word(make_word(KIND_APPEND, 32'h1234_5678, 63));  // oversized count
        offer_word(make_word(KIND_APPEND, 32'hDEAD_BEEF, 33));
        offer_word(make_word(KIND_APPEND, 32'hFFFF_FFF3, 5));   // junk above the count
        offer_word(make_word(KIND_APPEND, 32'h0000_005A, 8));
        offer_word(make_word(KIND_FLUSH, 32'h0, 0));
        offer_word(make_word(KIND_FLUSH, 32'h0, 0));
        offer_word(make_word(KIND_APPEND, 32'h7FFF_FFFF, 31));
        offer_word(make_word(KIND_APPEND, 32'h0000_0000, 1));
        offer_word(make_word(KIND_APPEND, 32'h0000_002A, 6));
        offer_word(make_word(KIND_APPEND, 32'hFFFF_FFFF, 0));   // empty append, bits pending
        offer_word(make_word(KIND_FLUSH, 32'h0, 0));

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            drain();
            case (phase)
                0: cap = '0;
                1: cap = stream_count + CAP_W'($urandom_range(10, 60));
                2: cap = CAPACITY_RESET;
                3: cap = CAP_W'(1);
                4: cap = stream_count + CAP_W'($urandom_range(20, 120));
                default: cap = CAP_W'($urandom);
            endcase
            write_capacity(cap);
            // Hold the result side off long enough for the block to back up.
            if (phase == 2) begin
                hold_req <= 1'b1;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (phase == 4 && n == ITEMS_PER_PHASE / 2) begin
                    drain();
                end
                offer_word(random_word());
            end
        end
        drain();

        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
